>>> sv/circulation_pump_controller_macros.svh
// Assertion macros for the circulation pump controller.
// Clocked on clock and disabled during reset of the including module.
`ifndef CIRCULATION_PUMP_CONTROLLER_MACROS_SVH
`define CIRCULATION_PUMP_CONTROLLER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define CPC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define CPC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CPC_ASSERT_IMP(label, ante, cons, msg)
`define CPC_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

>>> sv/cpc_pkg.sv
// Types, codes and reset values shared by the circulation pump controller.
// No dependencies.
`default_nettype none

package cpc_pkg;

   localparam int DEF_TIME_WIDTH = 32;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int TEMP_WIDTH = 12;
   localparam int DUR_WIDTH = 32;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_OFF = 2'd0;
   localparam mode_type MODE_ON = 2'd1;
   localparam mode_type MODE_AUTO = 2'd2;
   localparam mode_type MODE_ONCE = 2'd3;

   typedef logic [1:0] event_type;
   localparam event_type EVT_NONE = 2'd0;
   localparam event_type EVT_ON = 2'd1;
   localparam event_type EVT_OFF = 2'd2;

   typedef enum logic [4:0] {
      PH_BASE    = 5'b00001,
      PH_WAIT    = 5'b00010,
      PH_MIN_RUN = 5'b00100,
      PH_RUN     = 5'b01000,
      PH_PAUSE   = 5'b10000
   } phase_type;

   typedef logic [2:0] phase_code_type;
   localparam phase_code_type PHASE_CODE_BASE = 3'd0;
   localparam phase_code_type PHASE_CODE_WAIT = 3'd1;
   localparam phase_code_type PHASE_CODE_MIN_RUN = 3'd2;
   localparam phase_code_type PHASE_CODE_RUN = 3'd3;
   localparam phase_code_type PHASE_CODE_PAUSE = 3'd4;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   localparam csr_index_type REG_STOP_RULE = 3'd0;
   localparam csr_index_type REG_RETURN_TARGET = 3'd1;
   localparam csr_index_type REG_MAX_DIFFERENCE = 3'd2;
   localparam csr_index_type REG_MIN_RUN_MS = 3'd3;
   localparam csr_index_type REG_MAX_RUN_MS = 3'd4;
   localparam csr_index_type REG_PAUSE_MS = 3'd5;

   localparam logic RST_STOP_RULE = 1'b0;
   localparam logic signed [TEMP_WIDTH-1:0] RST_RETURN_TARGET = 12'sd560;
   localparam logic [TEMP_WIDTH-1:0] RST_MAX_DIFFERENCE = 12'd112;
   localparam logic [DUR_WIDTH-1:0] RST_MIN_RUN_MS = 32'd60000;
   localparam logic [DUR_WIDTH-1:0] RST_MAX_RUN_MS = 32'd1200000;
   localparam logic [DUR_WIDTH-1:0] RST_PAUSE_MS = 32'd1800000;

   typedef struct packed {
      logic                         command;
      mode_type                     new_mode;
      logic                         tick;
      logic signed [TEMP_WIDTH-1:0] temp_supply;
      logic signed [TEMP_WIDTH-1:0] temp_return;
   } req_type;

   typedef struct packed {
      logic           pump_on;
      event_type      switch_event;
      phase_code_type phase;
      mode_type       mode_now;
   } rsp_type;

   typedef struct packed {
      logic                         stop_rule;
      logic signed [TEMP_WIDTH-1:0] return_target;
      logic [TEMP_WIDTH-1:0]        max_difference;
      logic [DUR_WIDTH-1:0]         min_run_ms;
      logic [DUR_WIDTH-1:0]         max_run_ms;
      logic [DUR_WIDTH-1:0]         pause_ms;
   } cfg_type;

   typedef struct packed {
      mode_type  mode;
      mode_type  ret_mode;
      phase_type phase;
      logic      pump;
   } ctrl_type;

   function automatic phase_code_type phase_code(input phase_type ph);
      phase_code_type code;
      unique case (ph)
         PH_BASE:    code = PHASE_CODE_BASE;
         PH_WAIT:    code = PHASE_CODE_WAIT;
         PH_MIN_RUN: code = PHASE_CODE_MIN_RUN;
         PH_RUN:     code = PHASE_CODE_RUN;
         PH_PAUSE:   code = PHASE_CODE_PAUSE;
         default:    code = PHASE_CODE_BASE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

>>> sv/cpc_step.sv
// Next-state and result logic for one item of the pump controller.
// Depends on cpc_pkg.
`default_nettype none

module cpc_step #(
   parameter int TIME_WIDTH = cpc_pkg::DEF_TIME_WIDTH
) (
   input  cpc_pkg::cfg_type        cfg,
   input  cpc_pkg::ctrl_type       ctrl_cur,
   input  logic [TIME_WIDTH-1:0]   run_cur,
   input  logic [TIME_WIDTH-1:0]   pause_cur,
   input  cpc_pkg::req_type        item,
   output cpc_pkg::ctrl_type       ctrl_nxt,
   output logic [TIME_WIDTH-1:0]   run_nxt,
   output logic [TIME_WIDTH-1:0]   pause_nxt,
   output cpc_pkg::rsp_type        result
);

   localparam int CW = (TIME_WIDTH > cpc_pkg::DUR_WIDTH) ? TIME_WIDTH : cpc_pkg::DUR_WIDTH;

   logic [CW-1:0]                 min_x;
   logic [CW-1:0]                 max_x;
   logic [CW-1:0]                 pause_x;
   logic signed [11:0]            ret_t;
   logic signed [11:0]            sup_t;
   logic signed [11:0]            tgt_t;
   logic                          ret_low;
   logic [12:0]                   diff;
   logic [12:0]                   diff_abs;
   logic                          done;
   logic [TIME_WIDTH-1:0]         run_v;
   logic [TIME_WIDTH-1:0]         pause_v;
   cpc_pkg::phase_type            ph;
   cpc_pkg::mode_type             mode;
   cpc_pkg::mode_type             rmode;
   logic                          sw;
   cpc_pkg::event_type            evt;

   assign min_x = CW'(cfg.min_run_ms);
   assign max_x = CW'(cfg.max_run_ms);
   assign pause_x = CW'(cfg.pause_ms);
   assign ret_t = item.temp_return;
   assign sup_t = item.temp_supply;
   assign tgt_t = cfg.return_target;
   assign ret_low = $signed(ret_t) < $signed(tgt_t);
   assign diff = {ret_t[11], ret_t} - {sup_t[11], sup_t};
   assign diff_abs = diff[12] ? (~diff + 13'd1) : diff;
   assign done = cfg.stop_rule ? (diff_abs <= {1'b0, cfg.max_difference}) : !ret_low;

   always_comb begin
      run_v = run_cur;
      pause_v = pause_cur;
      ph = ctrl_cur.phase;
      mode = ctrl_cur.mode;
      rmode = ctrl_cur.ret_mode;
      sw = ctrl_cur.pump;
      evt = cpc_pkg::EVT_NONE;

      if (item.tick) begin
         if (run_v != '1) begin
            run_v = run_v + TIME_WIDTH'(1);
         end
         if (pause_v != '1) begin
            pause_v = pause_v + TIME_WIDTH'(1);
         end
      end

      if (item.command) begin
         mode = item.new_mode;
         if (item.new_mode != cpc_pkg::MODE_ONCE) begin
            rmode = item.new_mode;
         end
      end else if (mode == cpc_pkg::MODE_OFF || mode == cpc_pkg::MODE_ON) begin
         ph = cpc_pkg::PH_BASE;
         if (sw != (mode == cpc_pkg::MODE_ON)) begin
            sw = (mode == cpc_pkg::MODE_ON);
            evt = sw ? cpc_pkg::EVT_ON : cpc_pkg::EVT_OFF;
         end
      end else begin
         if (ph == cpc_pkg::PH_BASE) begin
            if (ret_low) begin
               ph = cpc_pkg::PH_MIN_RUN;
               run_v = '0;
               if (!sw) begin
                  sw = 1'b1;
                  evt = cpc_pkg::EVT_ON;
               end
            end else begin
               ph = cpc_pkg::PH_WAIT;
               if (sw) begin
                  sw = 1'b0;
                  evt = cpc_pkg::EVT_OFF;
               end
            end
         end
         if (ph == cpc_pkg::PH_WAIT && ret_low) begin
            ph = cpc_pkg::PH_MIN_RUN;
            run_v = '0;
            if (!sw) begin
               sw = 1'b1;
               evt = cpc_pkg::EVT_ON;
            end
         end
         if (ph == cpc_pkg::PH_MIN_RUN && CW'(run_v) >= min_x) begin
            ph = cpc_pkg::PH_RUN;
         end
         if (ph == cpc_pkg::PH_RUN && (done || CW'(run_v) >= max_x)) begin
            if (sw) begin
               sw = 1'b0;
               evt = cpc_pkg::EVT_OFF;
            end
            ph = cpc_pkg::PH_PAUSE;
            run_v = '0;
            pause_v = '0;
            if (mode == cpc_pkg::MODE_ONCE) begin
               mode = rmode;
            end
         end
         if (ph == cpc_pkg::PH_PAUSE && CW'(pause_v) >= pause_x) begin
            ph = cpc_pkg::PH_WAIT;
         end
      end

      ctrl_nxt.mode = mode;
      ctrl_nxt.ret_mode = rmode;
      ctrl_nxt.phase = ph;
      ctrl_nxt.pump = sw;
      run_nxt = run_v;
      pause_nxt = pause_v;
      result.pump_on = sw;
      result.switch_event = evt;
      result.phase = cpc_pkg::phase_code(ph);
      result.mode_now = mode;
   end

endmodule

`default_nettype wire

>>> sv/circulation_pump_controller.sv
// An accepted item is held in the input register, then its result in the result register.
// One item per cycle when not stalled, set by the single input and result registers.
// Reset: synchronous, active high; registers take their defaults, mode auto,
// phase base, pump off, elapsed counters zero, both channels empty.
// Depends on cpc_pkg, cpc_step and circulation_pump_controller_macros.svh.
`default_nettype none
`include "circulation_pump_controller_macros.svh"

module circulation_pump_controller #(
   parameter int TIME_WIDTH = cpc_pkg::DEF_TIME_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  cpc_pkg::req_type                      req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output cpc_pkg::rsp_type                      rsp_item,
   input  logic                                  csr_we,
   input  logic [cpc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [cpc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   cpc_pkg::cfg_type       cfg_ff;
   cpc_pkg::cfg_type       cfg_in;
   cpc_pkg::ctrl_type      ctrl_ff;
   cpc_pkg::ctrl_type      ctrl_in;
   cpc_pkg::ctrl_type      step_ctrl;
   logic [TIME_WIDTH-1:0]  run_ff;
   logic [TIME_WIDTH-1:0]  run_in;
   logic [TIME_WIDTH-1:0]  step_run;
   logic [TIME_WIDTH-1:0]  pause_ff;
   logic [TIME_WIDTH-1:0]  pause_in;
   logic [TIME_WIDTH-1:0]  step_pause;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   cpc_pkg::req_type       in_item_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   cpc_pkg::rsp_type       rsp_item_ff;
   cpc_pkg::rsp_type       step_rsp;
   logic                   step_fire;
   logic                   req_take;

   assign step_fire = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_fire;
   assign req_take = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   cpc_step #(
      .TIME_WIDTH(TIME_WIDTH)
   ) u_step (
      .cfg(cfg_ff),
      .ctrl_cur(ctrl_ff),
      .run_cur(run_ff),
      .pause_cur(pause_ff),
      .item(in_item_ff),
      .ctrl_nxt(step_ctrl),
      .run_nxt(step_run),
      .pause_nxt(step_pause),
      .result(step_rsp)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            cpc_pkg::REG_STOP_RULE:      cfg_in.stop_rule = csr_wdata[0];
            cpc_pkg::REG_RETURN_TARGET:  cfg_in.return_target = csr_wdata[11:0];
            cpc_pkg::REG_MAX_DIFFERENCE: cfg_in.max_difference = csr_wdata[11:0];
            cpc_pkg::REG_MIN_RUN_MS:     cfg_in.min_run_ms = csr_wdata;
            cpc_pkg::REG_MAX_RUN_MS:     cfg_in.max_run_ms = csr_wdata;
            cpc_pkg::REG_PAUSE_MS:       cfg_in.pause_ms = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   assign ctrl_in = step_fire ? step_ctrl : ctrl_ff;
   assign run_in = step_fire ? step_run : run_ff;
   assign pause_in = step_fire ? step_pause : pause_ff;
   assign in_valid_in = req_take || (in_valid_ff && !step_fire);
   assign rsp_valid_in = step_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_rule <= cpc_pkg::RST_STOP_RULE;
         cfg_ff.return_target <= cpc_pkg::RST_RETURN_TARGET;
         cfg_ff.max_difference <= cpc_pkg::RST_MAX_DIFFERENCE;
         cfg_ff.min_run_ms <= cpc_pkg::RST_MIN_RUN_MS;
         cfg_ff.max_run_ms <= cpc_pkg::RST_MAX_RUN_MS;
         cfg_ff.pause_ms <= cpc_pkg::RST_PAUSE_MS;
         ctrl_ff.mode <= cpc_pkg::MODE_AUTO;
         ctrl_ff.ret_mode <= cpc_pkg::MODE_AUTO;
         ctrl_ff.phase <= cpc_pkg::PH_BASE;
         ctrl_ff.pump <= 1'b0;
         run_ff <= '0;
         pause_ff <= '0;
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         ctrl_ff <= ctrl_in;
         run_ff <= run_in;
         pause_ff <= pause_in;
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (step_fire) begin
         rsp_item_ff <= step_rsp;
      end
   end

   `CPC_ASSERT_IMP(a_run_phase_pump_on, ctrl_ff.phase == cpc_pkg::PH_MIN_RUN || ctrl_ff.phase == cpc_pkg::PH_RUN, ctrl_ff.pump, "pump off during a run phase")
   `CPC_ASSERT_IMP(a_idle_phase_pump_off, ctrl_ff.phase == cpc_pkg::PH_WAIT || ctrl_ff.phase == cpc_pkg::PH_PAUSE, !ctrl_ff.pump, "pump on while waiting or pausing")
   `CPC_ASSERT_IMP(a_ret_mode_not_once, 1'b1, ctrl_ff.ret_mode != cpc_pkg::MODE_ONCE, "remembered mode is once")
   `CPC_ASSERT_IMP(a_event_matches_pump, rsp_valid_ff && rsp_item_ff.switch_event != cpc_pkg::EVT_NONE, rsp_item_ff.pump_on == (rsp_item_ff.switch_event == cpc_pkg::EVT_ON), "switch event disagrees with pump state")
   `CPC_ASSERT_NXT(a_take_holds_item, req_take, in_valid_ff, "accepted item lost")

endmodule

`default_nettype wire
